// ===== rtl/m3bl_pkg.sv =====
// Shared types, constants and helpers for the murmur3 bloom index generator.
// No dependencies; every other file imports this package.
`default_nettype none
package m3bl_pkg;

    localparam int MaxHashes = 64;
    localparam int WordW     = 64;
    localparam int CntW      = 5;
    localparam int NumW      = 6;

    localparam logic [63:0] MixC1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MixC2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FmixA = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FmixB = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] AddL  = 64'h0000000052dce729;
    localparam logic [63:0] AddH  = 64'h0000000038495ab5;

    localparam logic [CntW-1:0] FullBlk = 5'd16;

    typedef enum logic [0:0] {
        CFG_HASH_COUNT = 1'b0,
        CFG_MODULUS    = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        ST_OK    = 1'b0,
        ST_EMPTY = 1'b1
    } t_status;

    // classified block handed from the front queue to the engine
    typedef struct packed {
        logic [WordW-1:0] w0;
        logic [WordW-1:0] w1;
        logic             body;  // full body mix, else tail mix
        logic             last;
        logic [CntW-1:0]  len;   // bytes added to the total length
    } t_blk;

    typedef struct packed {
        logic [WordW-1:0] idx;
        logic [NumW-1:0]  num;
        t_status          status;
        logic             last;
    } t_res;

    typedef enum logic [4:0] {
        E_IDLE, E_L1A, E_L1B, E_APL, E_L2A, E_L2B, E_APH, E_CHK, E_ERR,
        E_F0, E_F1, E_M1A, E_M1B, E_M2A, E_M2B, E_F2, E_F3,
        E_RED, E_DGO, E_DWT, E_EMIT
    } t_eng_st;

    // low n bytes of a word kept, n in 0..8
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        if (n >= 4'd8) begin
            m = '1;
        end else begin
            m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
        return (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/m3bl_front.sv =====
// Front part: accepts input blocks, clamps and classifies them, and queues
// them (two deep) for the engine. Depends on m3bl_pkg.
`default_nettype none
module m3bl_front import m3bl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [WordW-1:0]  i_word_low,
    input  wire logic [WordW-1:0]  i_word_high,
    input  wire logic [CntW-1:0]   i_byte_count,
    input  wire logic              i_last_block,
    input  wire logic              i_take,
    output logic                   o_avail,
    output t_blk                   o_blk
);
    t_blk            r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic [CntW-1:0] cnt_c;
    logic            body_c;
    logic            tail_hi;
    t_blk            blk_c;
    logic            do_push, do_pop;

    always_comb begin
        cnt_c   = (i_byte_count > FullBlk) ? FullBlk : i_byte_count;
        body_c  = !i_last_block || (cnt_c == FullBlk);
        tail_hi = cnt_c > 5'd8;
        blk_c.body = body_c;
        blk_c.last = i_last_block;
        blk_c.len  = body_c ? FullBlk : cnt_c;
        if (body_c) begin
            blk_c.w0 = i_word_low;
            blk_c.w1 = i_word_high;
        end else begin
            blk_c.w0 = i_word_low & byte_mask(tail_hi ? 4'd8 : cnt_c[3:0]);
            blk_c.w1 = tail_hi ? (i_word_high & byte_mask(cnt_c[3:0] - 4'd8)) : '0;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_avail = r_cnt != 2'd0;
    assign o_blk   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= blk_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/m3bl_mul64.sv =====
// Iterative low-half 64x64 multiplier over one 32x32 multiplier.
// Depends on m3bl_pkg.
`default_nettype none
module m3bl_mul64 import m3bl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [WordW-1:0] i_a,
    input  wire logic [WordW-1:0] i_b,
    output logic                  o_done,
    output logic [WordW-1:0]      o_p
);
    logic [1:0]  r_ph;
    logic [63:0] r_lo;
    logic [31:0] r_x;
    logic [31:0] m_a, m_b;
    logic [63:0] prod;
    logic [31:0] mid;

    always_comb begin
        unique case (r_ph)
            2'd0:    begin m_a = i_a[31:0];  m_b = i_b[31:0];  end
            2'd1:    begin m_a = i_a[63:32]; m_b = i_b[31:0];  end
            default: begin m_a = i_a[31:0];  m_b = i_b[63:32]; end
        endcase
        prod = m_a * m_b;
        mid  = r_x + prod[31:0];
        o_p  = r_lo + {mid, 32'h0};
    end

    assign o_done = i_go && (r_ph == 2'd2);

    always_ff @(posedge i_clk) begin
        if (r_ph == 2'd0) r_lo <= prod;
        if (r_ph == 2'd1) r_x  <= prod[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !i_go || r_ph == 2'd2) begin
            r_ph <= 2'd0;
        end else begin
            r_ph <= r_ph + 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/m3bl_mod64.sv =====
// Restoring 64-bit remainder unit, one quotient bit per cycle.
// Depends on m3bl_pkg.
`default_nettype none
module m3bl_mod64 import m3bl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WordW-1:0] i_dvd,
    input  wire logic [WordW-1:0] i_dvs,
    output logic                  o_done,
    output logic [WordW-1:0]      o_rem
);
    logic            r_busy, r_done;
    logic [5:0]      r_cnt;
    logic [63:0]     r_dvd, r_rem;
    logic [64:0]     sh;
    logic            ge;
    logic [64:0]     diff;

    always_comb begin
        sh   = {r_rem, r_dvd[63]};
        ge   = sh >= {1'b0, i_dvs};
        diff = sh - {1'b0, i_dvs};
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= ge ? diff[63:0] : sh[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/m3bl_engine.sv =====
// Back part: sequencer for body/tail mixing, finalisation and index output.
// Depends on m3bl_pkg, m3bl_mul64, m3bl_mod64.
`default_nettype none
module m3bl_engine import m3bl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_avail,
    input  t_blk                  i_blk,
    output logic                  o_take,
    input  wire logic [NumW-1:0]  i_last_num,
    input  wire logic [WordW-1:0] i_modulus,
    input  wire logic             i_out_full,
    output logic                  o_res_vld,
    output t_res                  o_res
);
    t_eng_st      r_st, n_st;
    t_blk         r_blk;
    logic [63:0]  r_hl, r_hh, r_tot, r_t, r_v, r_d, r_idx;
    logic [NumW-1:0] r_i;

    logic         mul_go, mul_done;
    logic [63:0]  mul_a, mul_b, mul_p, mul_fx;
    logic         div_start, div_done;
    logic [63:0]  div_rem;
    logic [63:0]  mixl, mixh;

    m3bl_mul64 u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(mul_go),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    m3bl_mod64 u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dvd(r_v), .i_dvs(i_modulus), .o_done(div_done), .o_rem(div_rem)
    );

    always_comb begin
        mixl   = rotl(r_hl ^ r_t, 6'd27) + r_hh;
        mixl   = mixl + (mixl << 2) + AddL;
        mixh   = rotl(r_hh ^ r_t, 6'd31) + r_hl;
        mixh   = mixh + (mixh << 2) + AddH;
        mul_fx = mul_p ^ (mul_p >> 33);
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            E_IDLE: if (i_avail) n_st = E_L1A;
            E_L1A:  if (mul_done) n_st = E_L1B;
            E_L1B:  if (mul_done) n_st = E_APL;
            E_APL:  n_st = E_L2A;
            E_L2A:  if (mul_done) n_st = E_L2B;
            E_L2B:  if (mul_done) n_st = E_APH;
            E_APH:  n_st = r_blk.last ? E_CHK : E_IDLE;
            E_CHK:  n_st = (r_tot == '0) ? E_ERR : E_F0;
            E_ERR:  if (!i_out_full) n_st = E_IDLE;
            E_F0:   n_st = E_F1;
            E_F1:   n_st = E_M1A;
            E_M1A:  if (mul_done) n_st = E_M1B;
            E_M1B:  if (mul_done) n_st = E_M2A;
            E_M2A:  if (mul_done) n_st = E_M2B;
            E_M2B:  if (mul_done) n_st = E_F2;
            E_F2:   n_st = E_F3;
            E_F3:   n_st = E_RED;
            E_RED:  n_st = (i_modulus == '0) ? E_EMIT : E_DGO;
            E_DGO:  n_st = E_DWT;
            E_DWT:  if (div_done) n_st = E_EMIT;
            E_EMIT: if (!i_out_full) n_st = (r_i == i_last_num) ? E_IDLE : E_RED;
            default: n_st = E_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_take    = (r_st == E_IDLE) && i_avail;
        div_start = r_st == E_DGO;
        mul_go    = 1'b1;
        mul_a     = r_t ^ (r_t >> 33);
        mul_b     = FmixB;
        unique case (r_st)
            E_L1A: begin mul_a = r_blk.w0;               mul_b = MixC1; end
            E_L1B: begin mul_a = rotl(r_t, 6'd31);       mul_b = MixC2; end
            E_L2A: begin mul_a = r_blk.w1;               mul_b = MixC2; end
            E_L2B: begin mul_a = rotl(r_t, 6'd33);       mul_b = MixC1; end
            E_M1A: begin mul_a = r_hl ^ (r_hl >> 33);    mul_b = FmixA; end
            E_M2A: begin mul_a = r_hh ^ (r_hh >> 33);    mul_b = FmixA; end
            E_M1B, E_M2B: begin end
            default: mul_go = 1'b0;
        endcase
        o_res_vld = 1'b0;
        o_res.idx    = r_idx;
        o_res.num    = r_i;
        o_res.status = ST_OK;
        o_res.last   = r_i == i_last_num;
        if (r_st == E_ERR) begin
            o_res_vld    = !i_out_full;
            o_res.idx    = '0;
            o_res.num    = '0;
            o_res.status = ST_EMPTY;
            o_res.last   = 1'b1;
        end else if (r_st == E_EMIT) begin
            o_res_vld = !i_out_full;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl  <= '0;
            r_hh  <= '0;
            r_tot <= '0;
        end else begin
            unique case (r_st)
                E_APL: r_hl <= r_blk.body ? mixl : (r_hl ^ r_t);
                E_APH: begin
                    r_hh  <= r_blk.body ? mixh : (r_hh ^ r_t);
                    r_tot <= r_tot + {59'd0, r_blk.len};
                end
                E_ERR: if (!i_out_full) begin
                    r_hl <= '0;
                    r_hh <= '0;
                end
                E_F0: begin
                    r_hl <= (r_hl ^ r_tot) + (r_hh ^ r_tot);
                    r_hh <= r_hh ^ r_tot;
                end
                E_F1: r_hh <= r_hh + r_hl;
                E_M1B: if (mul_done) r_hl <= mul_fx;
                E_M2B: if (mul_done) r_hh <= mul_fx;
                E_F2: r_hl <= r_hl + r_hh;
                E_EMIT: if (!i_out_full && r_i == i_last_num) begin
                    r_hl  <= '0;
                    r_hh  <= '0;
                    r_tot <= '0;
                end
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_blk <= i_blk;
        if (mul_go && mul_done) r_t <= mul_p;
        if (r_st == E_F3) begin
            r_v <= r_hl;
            r_d <= r_hh + r_hl + 64'd1;
            r_i <= '0;
        end
        if (r_st == E_RED) r_idx <= r_v;
        if (r_st == E_DWT && div_done) r_idx <= div_rem;
        if (r_st == E_EMIT && !i_out_full) begin
            r_v <= r_v + r_d;
            r_d <= r_d + 64'd2;
            r_i <= r_i + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= E_IDLE;
        end else begin
            r_st <= n_st;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/murmur3_bloom_index_generator_core.sv =====
// Top level of the murmur3 bloom index generator: configuration registers,
// front queue, engine and a two-entry result queue.
// Depends on m3bl_pkg, m3bl_front, m3bl_engine.
//
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// input    | i_push / o_full        | i_word_low, i_word_high, i_byte_count,
//          |                        | i_last_block
// result   | o_empty / i_pop        | o_hash_index, o_hash_number, o_status,
//          |                        | o_last_of_run
// config   | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_wdata
//
// A non-final block takes four 64-bit products in the engine, each three
// passes through the shared 32x32 multiplier, plus two mix steps. A final
// block then adds finalisation (four more products) and emits each index
// through the bit-serial 64-bit remainder unit, bypassed with a zero modulus.
// Reset (synchronous, active low) clears the hash state and loads hash_count 4,
// modulus 1024. Both queues are two deep, so input and result sides stall
// independently; the engine stalls its output only on a full result queue.
`default_nettype none
module murmur3_bloom_index_generator_core import m3bl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WordW-1:0] i_word_low,
    input  wire logic [WordW-1:0] i_word_high,
    input  wire logic [CntW-1:0]  i_byte_count,
    input  wire logic             i_last_block,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic [WordW-1:0]      o_hash_index,
    output logic [NumW-1:0]       o_hash_number,
    output logic                  o_status,
    output logic                  o_last_of_run,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [WordW-1:0] i_cfg_wdata
);
    logic [6:0]      r_hash_count;
    logic [63:0]     r_modulus;
    logic [NumW-1:0] last_num;

    logic            avail, take;
    t_blk            blk;
    logic            res_vld;
    t_res            res;

    t_res            r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            q_full, q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count <= 7'd4;
            r_modulus    <= 64'd1024;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HASH_COUNT: r_hash_count <= i_cfg_wdata[6:0];
                CFG_MODULUS:    r_modulus    <= i_cfg_wdata;
                default:        begin end
            endcase
        end
    end

    // index of the final result: count clamped to 1..MaxHashes, minus one
    always_comb begin
        priority if (r_hash_count == 7'd0) begin
            last_num = '0;
        end else if (r_hash_count > 7'(MaxHashes)) begin
            last_num = NumW'(MaxHashes - 1);
        end else begin
            last_num = NumW'(r_hash_count - 7'd1);
        end
    end

    m3bl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_word_low(i_word_low), .i_word_high(i_word_high),
        .i_byte_count(i_byte_count), .i_last_block(i_last_block),
        .i_take(take), .o_avail(avail), .o_blk(blk)
    );

    m3bl_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_avail(avail), .i_blk(blk), .o_take(take),
        .i_last_num(last_num), .i_modulus(r_modulus),
        .i_out_full(q_full), .o_res_vld(res_vld), .o_res(res)
    );

    // result queue: each transaction is one index
    assign q_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign q_pop   = i_pop && !o_empty;

    assign o_hash_index  = r_q[r_rp].idx;
    assign o_hash_number = r_q[r_rp].num;
    assign o_status      = r_q[r_rp].status;
    assign o_last_of_run = r_q[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (res_vld) r_q[r_wp] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (res_vld) r_wp <= !r_wp;
            if (q_pop)   r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, res_vld} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire
